// File: rtl/barometric_sensor_compensation_macros.svh
// Assertion macros for the barometric compensation checker.
// No dependencies.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BSC_ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BSC_ASSERT(lbl, prop, msg) \
  `BSC_ASSERT_IMPL(lbl, clk_i, rst_ni, prop, msg)
`endif

// File: rtl/bsc_pkg.sv
// Package for the barometric compensation block: register indexes, widths, constants.
// No dependencies.
`timescale 1ns / 1ps
package bsc_pkg;
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_AC = 3'd0, CFG_ACU = 3'd1, CFG_B = 3'd2, CFG_M = 3'd3, CFG_OSS = 3'd4
  } cfg_idx_e;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 64;
  localparam int unsigned DivStages = 32;
  localparam logic [31:0] K_T_OFF  = 32'd4000;
  localparam logic [31:0] K_B4_OFF = 32'd32768;
  localparam logic [31:0] K_B7_MUL = 32'd50000;
  localparam logic [31:0] K_P1     = 32'd3038;
  localparam logic [31:0] K_P2     = 32'hFFFF_E343;
  localparam logic [31:0] K_P3     = 32'd3791;

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    asr = 32'($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    mul = p[31:0];
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction
endpackage

// File: rtl/bsc_div.sv
// Pipelined 32-bit unsigned restoring divider with side-band payload.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_div
  import bsc_pkg::*;
#(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      num_i,
  input  logic [31:0]      den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [31:0]      quo_o,
  output logic [SideW-1:0] side_o
);
  logic [DivStages:1]            vld_q;
  logic [DivStages:1][31:0]      rem_q;
  logic [DivStages:1][31:0]      num_q;
  logic [DivStages:1][31:0]      den_q;
  logic [DivStages:1][SideW-1:0] side_q;

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic             vin;
    logic [31:0]      rin;
    logic [31:0]      nin;
    logic [31:0]      din;
    logic [SideW-1:0] sin;
    logic [32:0]      trial;
    logic [32:0]      diff;
    if (s == 0) begin : g_first
      assign vin = valid_i;
      assign rin = '0;
      assign nin = num_i;
      assign din = den_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = vld_q[s];
      assign rin = rem_q[s];
      assign nin = num_q[s];
      assign din = den_q[s];
      assign sin = side_q[s];
    end
    assign trial = {rin, nin[31]};
    assign diff  = trial - {1'b0, din};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= diff[32] ? trial[31:0] : diff[31:0];
        num_q[s+1]  <= {nin[30:0], ~diff[32]};
        den_q[s+1]  <= din;
        side_q[s+1] <= sin;
      end
    end
  end

  assign valid_o = vld_q[DivStages];
  assign quo_o   = num_q[DivStages];
  assign side_o  = side_q[DivStages];
endmodule

// File: rtl/barometric_sensor_compensation.sv
// Channel  | dir | handshake                  | payload
// in       | in  | s_axis_tvalid/tready       | raw_temp, raw_press
// out      | out | m_axis_tvalid/tready       | temp_tenths, press_pa, div_error
// cfg      | in  | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
// One item per cycle while the output is not stalled; the path runs through two
// 32-stage divider pipelines and nine further register stages.
// Reset clears all valid bits and calibration registers.
// A stall on the output holds every stage; no item is lost or repeated.
// Depends on bsc_pkg and bsc_div.
`timescale 1ns / 1ps
module barometric_sensor_compensation
  import bsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // raw_temp[15:0], raw_press[34:16]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // temp_tenths[31:0], press_pa[63:32]
  output logic                m_axis_tuser,   // div_error
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  logic [47:0] ac_q, acu_q;
  logic [31:0] b_q, m_q;
  logic [1:0]  oss_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_q <= '0; acu_q <= '0; b_q <= '0; m_q <= '0; oss_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AC:  ac_q  <= cfg_data_i;
        CFG_ACU: acu_q <= cfg_data_i;
        CFG_B:   b_q   <= cfg_data_i[31:0];
        CFG_M:   m_q   <= cfg_data_i[31:0];
        CFG_OSS: oss_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(ac_q[47:32]);
  assign ac2 = sx16(ac_q[31:16]);
  assign ac3 = sx16(ac_q[15:0]);
  assign ac4 = {16'd0, acu_q[47:32]};
  assign ac5 = {16'd0, acu_q[31:16]};
  assign ac6 = {16'd0, acu_q[15:0]};
  assign b1  = sx16(b_q[31:16]);
  assign b2  = sx16(b_q[15:0]);
  assign mc  = sx16(m_q[31:16]);
  assign md  = sx16(m_q[15:0]);

  // Global stall: everything advances when the output register can take.
  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: ut-ac6 times ac5
  logic        v1_q;
  logic [31:0] m1_q, up1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q  <= mul({16'd0, s_axis_tdata[15:0]} - ac6, ac5);
      up1_q <= {13'd0, s_axis_tdata[34:16]};
    end
  end

  // Stage 2: x1, dv, dividend with sign handling
  logic [31:0] x1a, dva, nma, ma, mb;
  logic        v2_q;
  logic [31:0] x1_2_q, ma_q, mb_q, up2_q;
  logic        neg2_q, dz2_q;
  assign x1a = asr(m1_q, 5'd15);
  assign dva = x1a + md;
  assign nma = (mc << 11) - 32'($signed(dva) / 2);
  assign ma  = nma[31] ? 32'd0 - nma : nma;
  assign mb  = dva[31] ? 32'd0 - dva : dva;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_2_q <= x1a;
      ma_q   <= ma;
      mb_q   <= (dva == 32'd0) ? 32'd1 : mb;
      neg2_q <= nma[31] ^ dva[31];
      dz2_q  <= (dva == 32'd0);
      up2_q  <= up1_q;
    end
  end

  localparam int unsigned S1W = 32 + 32 + 1 + 1;
  logic             v3;
  logic [31:0]      q3;
  logic [S1W-1:0]   s3;
  bsc_div #(.SideW(S1W)) u_div_t (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q), .num_i(ma_q), .den_i(mb_q),
    .side_i({x1_2_q, up2_q, neg2_q, dz2_q}), .valid_o(v3), .quo_o(q3), .side_o(s3)
  );

  // Stage 4: b5, temp, b6, products
  logic [31:0] x2t, b5, b6;
  assign x2t = s3[1] ? 32'd0 - q3 : q3;
  assign b5  = s3[S1W-1 -: 32] + x2t;
  assign b6  = b5 - K_T_OFF;
  logic        v4_q, dz4_q;
  logic [31:0] tmp4_q, b6_4_q, sq4m_q, up4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      tmp4_q <= asr(b5 + 32'd8, 5'd4);
      b6_4_q <= b6;
      sq4m_q <= mul(b6, b6);
      up4_q  <= s3[33:2];
      dz4_q  <= s3[0];
    end
  end

  // Stage 5: products with sq and b6
  logic [31:0] sq5;
  assign sq5 = asr(sq4m_q, 5'd12);
  logic        v5_q, dz5_q;
  logic [31:0] tmp5_q, p1_q, p2_q, p3_q, p4_q, up5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= mul(b2, sq5);
      p2_q <= mul(ac2, b6_4_q);
      p3_q <= mul(ac3, b6_4_q);
      p4_q <= mul(b1, sq5);
      tmp5_q <= tmp4_q; up5_q <= up4_q; dz5_q <= dz4_q;
    end
  end

  // Stage 6: b3 and x3
  logic [31:0] x3a, b3n, b3, x3b;
  assign x3a = asr(p1_q, 5'd11) + asr(p2_q, 5'd11);
  assign b3n = ((ac1 * 32'd4 + x3a) << oss_q) + 32'd2;
  assign b3  = 32'($signed(b3n) / 4);
  assign x3b = asr(asr(p3_q, 5'd13) + asr(p4_q, 5'd16) + 32'd2, 5'd2);
  logic        v6_q, dz6_q;
  logic [31:0] tmp6_q, b4m6_q, d6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b4m6_q <= mul(ac4, x3b + K_B4_OFF);
      d6_q   <= up5_q - b3;
      tmp6_q <= tmp5_q; dz6_q <= dz5_q;
    end
  end

  // Stage 7: b7, b4
  logic        v7_q, dz7_q;
  logic [31:0] tmp7_q, b4_7_q, b7_7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b4_7_q <= b4m6_q >> 15;
      b7_7_q <= mul(d6_q, K_B7_MUL >> oss_q);
      tmp7_q <= tmp6_q; dz7_q <= dz6_q;
    end
  end

  logic        dz7;
  logic [31:0] pn7;
  assign dz7 = dz7_q || (b4_7_q == 32'd0);
  assign pn7 = b7_7_q[31] ? b7_7_q : (b7_7_q << 1);
  localparam int unsigned S2W = 32 + 1 + 1;
  logic           v8;
  logic [31:0]    q8;
  logic [S2W-1:0] s8;
  bsc_div #(.SideW(S2W)) u_div_p (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v7_q), .num_i(pn7),
    .den_i(dz7 ? 32'd1 : b4_7_q), .side_i({tmp7_q, b7_7_q[31], dz7}),
    .valid_o(v8), .quo_o(q8), .side_o(s8)
  );

  // Stage 9: p and products
  logic [31:0] p9, ps9;
  assign p9  = s8[1] ? (q8 << 1) : q8;
  assign ps9 = asr(p9, 5'd8);
  logic        v9_q, dz9_q;
  logic [31:0] tmp9_q, p9_q, sq9_q, m9_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else if (en) v9_q <= v8;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p9_q  <= p9;
      sq9_q <= mul(ps9, ps9);
      m9_q  <= mul(K_P2, p9);
      tmp9_q <= s8[S2W-1 -: 32]; dz9_q <= s8[0];
    end
  end

  // Stage 10
  logic        v10_q, dz10_q;
  logic [31:0] tmp10_q, p10_q, m10_q, x2_10_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v10_q <= 1'b0;
    else if (en) v10_q <= v9_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m10_q   <= mul(sq9_q, K_P1);
      x2_10_q <= asr(m9_q, 5'd16);
      p10_q <= p9_q; tmp10_q <= tmp9_q; dz10_q <= dz9_q;
    end
  end

  // Output register
  logic [31:0] pf;
  assign pf = p10_q + asr(asr(m10_q, 5'd16) + x2_10_q + K_P3, 5'd4);
  logic [31:0] ot_q, op_q;
  logic        oe_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= v10_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ot_q <= dz10_q ? 32'd0 : tmp10_q;
      op_q <= dz10_q ? 32'd0 : pf;
      oe_q <= dz10_q;
    end
  end
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {op_q, ot_q};
  assign m_axis_tuser  = oe_q;
endmodule

// File: rtl/bsc_checker.sv
// Port-level checker for the barometric compensation block, with its bind.
// Depends on bsc_pkg and barometric_sensor_compensation_macros.svh.
`timescale 1ns / 1ps
`include "barometric_sensor_compensation_macros.svh"
module bsc_checker
  import bsc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                cfg_ready_o
);
  `BSC_ASSERT(a_err_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "error item not zero")
  `BSC_ASSERT(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")
  `BSC_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output item changed under stall")
  `BSC_ASSERT(a_cfg, cfg_ready_o, "config port not ready")
endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser, .cfg_ready_o
);
